FILE: src/mwma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mwma_pkg: shared types and constants of the moving average core
// Field widths, configuration reset values, controller state codes and the
// command and status groups between the controller and the datapath.
// ---------------------------------------------------------------------------
package mwma_pkg;

    // Field widths of prices and window lengths.
    localparam int PRICE_W     = 24;
    localparam int WIN_W       = 7;

    // Number of averaging windows, one configuration register each.
    localparam int NUM_WINDOWS = 4;
    localparam int IDX_W       = $clog2(NUM_WINDOWS);

    // A sum of up to 127 prices of 24 bits.
    localparam int SUM_W       = PRICE_W + WIN_W;

    // Every quotient fits the price width, so one divide takes PRICE_W steps.
    localparam int DIV_STEPS   = PRICE_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [WIN_W-1:0]   win_t;

    // Window lengths after reset.
    localparam win_t WIN_RESET [NUM_WINDOWS] = '{7'd5, 7'd10, 7'd30, 7'd60};

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SWEEP  = 5'b00010,
        ST_LOAD   = 5'b00100,
        ST_STEP   = 5'b01000,
        ST_FINISH = 5'b10000
    } mwma_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic sweep;
        logic div_load;
        logic div_step;
        logic out_load;
    } mwma_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_done;
        logic step_last;
        logic win_last;
    } mwma_status_t;

endpackage
`default_nettype wire

FILE: src/mwma_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mwma_if: request channels of the moving average core
// One channel carries prices in, the other carries the four averages out.
// ---------------------------------------------------------------------------
interface mwma_in_if;
    import mwma_pkg::*;

    logic   valid;
    logic   ready;
    price_t price;
    logic   last_of_series;

    modport source (output valid, output price, output last_of_series, input ready);
    modport sink   (input valid, input price, input last_of_series, output ready);
endinterface

interface mwma_out_if;
    import mwma_pkg::*;

    logic   valid;
    logic   ready;
    price_t avg_a;
    price_t avg_b;
    price_t avg_c;
    price_t avg_d;

    modport source (output valid, output avg_a, output avg_b, output avg_c,
                    output avg_d, input ready);
    modport sink   (input valid, input avg_a, input avg_b, input avg_c,
                    input avg_d, output ready);
endinterface
`default_nettype wire

FILE: src/mwma_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mwma_ctrl: sequencing controller of the moving average core
// Accepts a price, runs the history sweep, then four serial divides, and
// hands the result to the output register.
// ---------------------------------------------------------------------------
module mwma_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  mwma_pkg::mwma_status_t status,
    output mwma_pkg::mwma_cmd_t    cmd
);
    import mwma_pkg::*;

    mwma_state_t state_reg;
    mwma_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // A new request is taken only between items.
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.div_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = status.win_last ? ST_FINISH : ST_LOAD;
                end
            end
            ST_FINISH:
            begin
                // Wait until the output register is free or being emptied.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag follows loads and completed requests.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/mwma_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mwma_dp: datapath of the moving average core
// Holds the window registers, the price history ring, the four running sums,
// a shared restoring divider and the output register.
// ---------------------------------------------------------------------------
module mwma_dp #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mwma_pkg::mwma_cmd_t         cmd,
    output mwma_pkg::mwma_status_t      status,
    input  mwma_pkg::price_t            price,
    input  logic                        last_of_series,
    input  logic                        cfg_we,
    input  logic [mwma_pkg::IDX_W-1:0]  cfg_index,
    input  mwma_pkg::win_t              cfg_wdata,
    output mwma_pkg::price_t            avg [mwma_pkg::NUM_WINDOWS]
);
    import mwma_pkg::*;

    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int CMPW = (CW > WIN_W) ? CW : WIN_W;

    localparam logic [AW:0]     DEPTH_C   = (AW + 1)'(MAX_WINDOW);
    localparam logic [AW-1:0]   LAST_SLOT = AW'(MAX_WINDOW - 1);
    localparam logic [CMPW-1:0] MAX_C     = CMPW'(MAX_WINDOW);
    localparam logic [CMPW-1:0] ONE_C     = CMPW'(1);
    localparam logic [CMPW-1:0] TWO_C     = CMPW'(2);
    localparam logic [CW-1:0]   SEEN_MAX  = CW'(MAX_WINDOW);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);
    localparam logic [IDX_W-1:0]  SEL_LAST  = IDX_W'(NUM_WINDOWS - 1);

    // Configuration and series state.
    win_t              window_reg [NUM_WINDOWS];
    price_t            hist_mem   [MAX_WINDOW];
    logic [AW-1:0]     ws_reg;
    logic [CW-1:0]     seen_reg;

    // History sweep.
    logic [AW-1:0]     rd_ptr_reg;
    price_t            rdata_reg;
    logic              rd_valid_reg;
    win_t              rd_k_reg;
    win_t              k_reg;
    win_t              len_reg;
    win_t              n_reg      [NUM_WINDOWS];
    logic              en_reg     [NUM_WINDOWS];
    logic [SUM_W-1:0]  sum_reg    [NUM_WINDOWS];

    // Shared divider and results.
    logic [IDX_W-1:0]  sel_reg;
    win_t              rem_reg;
    price_t            quo_reg;
    logic [STEP_W-1:0] step_reg;
    price_t            res_reg    [NUM_WINDOWS];
    price_t            avg_reg    [NUM_WINDOWS];

    // Per-item window set-up from the registers and the updated count.
    logic [CW-1:0]     seen_inc;
    logic [CMPW-1:0]   eff_len    [NUM_WINDOWS];
    win_t              n_new      [NUM_WINDOWS];
    logic              en_new     [NUM_WINDOWS];
    win_t              len_new;
    logic [AW:0]       ws_inc;

    // Divider step.
    logic [WIN_W:0]    div_shift;
    logic [WIN_W:0]    div_den;
    logic [WIN_W:0]    div_diff;
    logic              div_ge;
    price_t            quo_new;

    assign seen_inc = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + 1'b1;
    assign ws_inc   = {1'b0, ws_reg} + 1'b1;

    // Clamp each window to 1..MAX_WINDOW and decide whether it has warmed up.
    always_comb
    begin
        len_new = '0;
        for (int c = 0; c < NUM_WINDOWS; c++)
        begin
            eff_len[c] = CMPW'(window_reg[c]);
            if (eff_len[c] == '0)
            begin
                eff_len[c] = ONE_C;
            end
            else if (eff_len[c] > MAX_C)
            begin
                eff_len[c] = MAX_C;
            end
            n_new[c]  = WIN_W'(eff_len[c]);
            en_new[c] = (eff_len[c] >= TWO_C) && (CMPW'(seen_inc) >= eff_len[c]);
            if (en_new[c] && (n_new[c] > len_new))
            begin
                len_new = n_new[c];
            end
        end
    end

    // Restoring divide step: one quotient bit per cycle.
    assign div_shift = {rem_reg, quo_reg[PRICE_W-1]};
    assign div_den   = {1'b0, n_reg[sel_reg]};
    assign div_ge    = (div_shift >= div_den);
    assign div_diff  = div_shift - div_den;
    assign quo_new   = {quo_reg[PRICE_W-2:0], div_ge};

    assign status.sweep_done = (k_reg == len_reg) && !rd_valid_reg;
    assign status.step_last  = (step_reg == STEP_LAST);
    assign status.win_last   = (sel_reg == SEL_LAST);

    always_comb
    begin
        for (int c = 0; c < NUM_WINDOWS; c++)
        begin
            avg[c] = avg_reg[c];
        end
    end

    // History memory: written on accept, read once a cycle during the sweep.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hist_mem[ws_reg] <= price;
        end
        if (cmd.sweep && (k_reg < len_reg))
        begin
            rdata_reg <= hist_mem[rd_ptr_reg];
        end
    end

    // Configuration, ring position, count and sequencing counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_WINDOWS; c++)
            begin
                window_reg[c] <= WIN_RESET[c];
                en_reg[c]     <= 1'b0;
            end
            ws_reg       <= '0;
            seen_reg     <= '0;
            rd_valid_reg <= 1'b0;
            k_reg        <= '0;
            len_reg      <= '0;
            sel_reg      <= '0;
            step_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg[cfg_index] <= cfg_wdata;
            end

            if (cmd.accept)
            begin
                if (last_of_series)
                begin
                    ws_reg   <= '0;
                    seen_reg <= '0;
                end
                else
                begin
                    ws_reg   <= (ws_inc == DEPTH_C) ? '0 : ws_inc[AW-1:0];
                    seen_reg <= seen_inc;
                end
                for (int c = 0; c < NUM_WINDOWS; c++)
                begin
                    en_reg[c] <= en_new[c];
                end
                len_reg      <= len_new;
                k_reg        <= '0;
                rd_valid_reg <= 1'b0;
                sel_reg      <= '0;
            end

            if (cmd.sweep)
            begin
                if (k_reg < len_reg)
                begin
                    k_reg        <= k_reg + 1'b1;
                    rd_valid_reg <= 1'b1;
                end
                else
                begin
                    rd_valid_reg <= 1'b0;
                end
            end

            if (cmd.div_load)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + 1'b1;
                if (status.step_last)
                begin
                    sel_reg <= status.win_last ? '0 : sel_reg + 1'b1;
                end
            end
        end
    end

    // Payload: read pointer, sums, divider operands and results.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_ptr_reg <= ws_reg;
            for (int c = 0; c < NUM_WINDOWS; c++)
            begin
                n_reg[c]   <= n_new[c];
                sum_reg[c] <= '0;
            end
        end

        // Walk backward from the newest price.
        if (cmd.sweep && (k_reg < len_reg))
        begin
            rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_SLOT : rd_ptr_reg - 1'b1;
            rd_k_reg   <= k_reg;
        end

        // Each window takes the prices that fall inside its length.
        if (rd_valid_reg)
        begin
            for (int c = 0; c < NUM_WINDOWS; c++)
            begin
                if (en_reg[c] && (rd_k_reg < n_reg[c]))
                begin
                    sum_reg[c] <= sum_reg[c] + SUM_W'(rdata_reg);
                end
            end
        end

        // The upper sum bits are below the divisor, so they seed the remainder.
        if (cmd.div_load)
        begin
            rem_reg <= sum_reg[sel_reg][SUM_W-1:PRICE_W];
            quo_reg <= sum_reg[sel_reg][PRICE_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_diff[WIN_W-1:0] : div_shift[WIN_W-1:0];
            quo_reg <= quo_new;
            if (status.step_last)
            begin
                res_reg[sel_reg] <= quo_new;
            end
        end

        if (cmd.out_load)
        begin
            for (int c = 0; c < NUM_WINDOWS; c++)
            begin
                avg_reg[c] <= res_reg[c];
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/multi_window_moving_average_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// multi_window_moving_average_core: four-window simple moving average
// Gives the truncated mean of the last N prices of the current series for
// four configurable window lengths, one result per price.
// ---------------------------------------------------------------------------
// Channel    Dir   Contents
// samples    in    price, last_of_series
// averages   out   avg_a, avg_b, avg_c, avg_d
// cfg        in    cfg_we, cfg_index, cfg_wdata (window_a .. window_d)
//
// After acceptance, the history sweep reads one ring entry a cycle over the
// longest warmed-up window L (2 to 64), or no entries when no window has
// warmed up; the shared divider then loads and forms 24 quotient bits for
// each window before the result is loaded.
// A new price is accepted while the previous result still waits on averages;
// a finished result holds in the controller until the output register frees.
// Reset is asynchronous; the history ring needs no clearing pass.
// ---------------------------------------------------------------------------
module multi_window_moving_average_core #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    mwma_in_if.sink                    samples,
    mwma_out_if.source                 averages,
    input  logic                       cfg_we,
    input  logic [mwma_pkg::IDX_W-1:0] cfg_index,
    input  mwma_pkg::win_t             cfg_wdata
);
    import mwma_pkg::*;

    mwma_cmd_t    cmd;
    mwma_status_t status;
    price_t       avg [NUM_WINDOWS];

    // Sequencing.
    mwma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (averages.valid),
        .out_ready (averages.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // History, sums and divider.
    mwma_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .price          (samples.price),
        .last_of_series (samples.last_of_series),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .avg            (avg)
    );

    // Result fields.
    assign averages.avg_a = avg[0];
    assign averages.avg_b = avg[1];
    assign averages.avg_c = avg[2];
    assign averages.avg_d = avg[3];

endmodule
`default_nettype wire

FILE: bench/multi_window_moving_average_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_window_moving_average_core_tb: self-checking bench for the SMA core
// Streams price requests through the core under several window settings and
// checks every average request against a cycle-free model of the four
// moving averages kept inside the bench. Both channels stall at random.
// ---------------------------------------------------------------------------
module multi_window_moving_average_core_tb;
    import mwma_pkg::*;

    localparam int MAX_WINDOW  = 64;
    // Cycles without any accepted request before the run is abandoned.
    localparam int STALL_LIMIT = 2000;
    // Longest processing time of one price, with margin.
    localparam int DRAIN_WAIT  = 200;
    localparam int SETTLE_WAIT = 8;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW_A = 2'd0,
        REG_WINDOW_B = 2'd1,
        REG_WINDOW_C = 2'd2,
        REG_WINDOW_D = 2'd3
    } window_reg_t;

    // The four averages of one result request.
    typedef struct {
        price_t avg [NUM_WINDOWS];
    } avg_set_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_we;
    logic [IDX_W-1:0] cfg_index;
    win_t           cfg_wdata;

    mwma_in_if  in_ch ();
    mwma_out_if out_ch ();

    multi_window_moving_average_core #(
        .MAX_WINDOW (MAX_WINDOW)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (in_ch),
        .averages  (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Bench copy of the core state.
    win_t     window_len [NUM_WINDOWS] = WIN_RESET;
    price_t   price_ring [MAX_WINDOW];
    int       ring_slot    = 0;
    int       series_fill  = 0;

    avg_set_t expected_avgs [$];

    int idle_odds      = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;
    int prices_sent    = 0;
    int series_sent    = 0;
    int results_seen   = 0;
    int window_writes  = 0;

    string field_name [NUM_WINDOWS] = '{"avg_a", "avg_b", "avg_c", "avg_d"};

    // Clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Window length as the core uses it: clamped to 1 .. MAX_WINDOW.
    function automatic int effective_len(input win_t raw);
        if (raw < 1)
            return 1;
        if (raw > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(raw);
    endfunction

    function automatic int longest_window();
        int span;
        span = 1;
        for (int w = 0; w < NUM_WINDOWS; w++)
        begin
            if (effective_len(window_len[w]) > span)
                span = effective_len(window_len[w]);
        end
        return span;
    endfunction

    // Stores one price in the ring and forms the four window means.
    function automatic avg_set_t predict_averages(input price_t value, input logic ends_series);
        avg_set_t         result;
        int               n;
        int               slot;
        longint unsigned  total;
        price_ring[ring_slot] = value;
        ring_slot = (ring_slot == MAX_WINDOW - 1) ? 0 : ring_slot + 1;
        if (series_fill < MAX_WINDOW)
            series_fill++;
        for (int w = 0; w < NUM_WINDOWS; w++)
        begin
            n = effective_len(window_len[w]);
            result.avg[w] = '0;
            // A window stays at zero until it holds n prices of this series.
            if (n >= 2 && series_fill >= n)
            begin
                total = 0;
                slot  = ring_slot;
                for (int k = 0; k < n; k++)
                begin
                    slot = (slot == 0) ? MAX_WINDOW - 1 : slot - 1;
                    total += price_ring[slot];
                end
                result.avg[w] = price_t'(total / n);
            end
        end
        // The result of the closing price is formed first, then history restarts.
        if (ends_series)
        begin
            series_fill = 0;
            ring_slot   = 0;
        end
        return result;
    endfunction

    // Prices lean toward the extremes now and then.
    function automatic price_t random_price();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return price_t'($urandom);
        endcase
    endfunction

    // Sends one price request and records the averages it must produce.
    task automatic send_price(input price_t value, input logic ends_series);
        if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.price          <= value;
        in_ch.last_of_series <= ends_series;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_avgs.push_back(predict_averages(value, ends_series));
        prices_sent++;
        if (ends_series)
            series_sent++;
    endtask

    // Holds off new prices until every outstanding average has come back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_avgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // One register write; the caller lowers the write enable afterward.
    task automatic write_window(input window_reg_t idx, input win_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        window_len[int'(idx)] = value;
        window_writes++;
    endtask

    task automatic write_all_windows(input win_t a, input win_t b, input win_t c, input win_t d);
        wait_drained();
        write_window(REG_WINDOW_A, a);
        write_window(REG_WINDOW_B, b);
        write_window(REG_WINDOW_C, c);
        write_window(REG_WINDOW_D, d);
        cfg_we <= 1'b0;
    endtask

    // Reset windows: the first window warms up after five full-scale prices.
    task automatic test_default_windows();
        idle_odds = 25;
        repeat (5) send_price('1, 1'b0);
        send_price('0, 1'b1);
    endtask

    // Windows of zero and one never average; a two-long window does.
    task automatic test_short_windows();
        write_all_windows(7'd0, 7'd1, 7'd2, 7'd3);
        send_price('0, 1'b0);
        send_price('1, 1'b0);
        send_price('1, 1'b0);
        send_price(24'd1, 1'b1);
        // A series made of a single price.
        send_price(24'hABCDEF, 1'b1);
    endtask

    // New lengths take effect at once on the series already under way.
    task automatic test_window_change();
        write_all_windows(7'd2, 7'd3, 7'd4, 7'd64);
        send_price(24'd10, 1'b0);
        send_price(24'd20, 1'b0);
        send_price(24'd30, 1'b0);
        wait_drained();
        write_window(REG_WINDOW_A, 7'd4);
        write_window(REG_WINDOW_D, 7'd127);
        cfg_we <= 1'b0;
        send_price(24'd40, 1'b0);
        send_price(24'h800000, 1'b1);
    endtask

    // Random series, mostly long enough to warm up every window.
    task automatic test_random_series(input int items, input int odds);
        int sent;
        int span;
        int len;
        idle_odds = odds;
        sent      = 0;
        while (sent < items)
        begin
            span = longest_window();
            if ($urandom_range(0, 3) != 0)
                len = span + $urandom_range(0, 20);
            else
                len = $urandom_range(1, span);
            for (int pos = 0; pos < len && sent < items; pos++)
            begin
                // Now and then a window is rewritten in the middle of a series.
                if ($urandom_range(0, 79) == 0)
                begin
                    wait_drained();
                    write_window(window_reg_t'($urandom_range(0, 3)), win_t'($urandom_range(0, 127)));
                    cfg_we <= 1'b0;
                end
                send_price(random_price(), pos == len - 1);
                sent++;
            end
        end
    endtask

    // Result side stalls in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0 && idle_odds > 0 && $urandom_range(0, 99) < idle_odds)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Compares each accepted average request with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        avg_set_t want;
        price_t   got [NUM_WINDOWS];
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got[0] = out_ch.avg_a;
            got[1] = out_ch.avg_b;
            got[2] = out_ch.avg_c;
            got[3] = out_ch.avg_d;
            results_seen++;
            if (expected_avgs.size() == 0)
            begin
                $display("%0t: unexpected averages request: %0d %0d %0d %0d",
                         $time, got[0], got[1], got[2], got[3]);
                mismatch_count++;
            end
            else
            begin
                want = expected_avgs.pop_front();
                for (int w = 0; w < NUM_WINDOWS; w++)
                begin
                    if (got[w] !== want.avg[w])
                    begin
                        $display("%0t: %s mismatch: expected %0d, actual %0d",
                                 $time, field_name[w], want.avg[w], got[w]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles, %0d averages outstanding",
                         $time, quiet_cycles, expected_avgs.size());
                $display("multi_window_moving_average_core_tb: errors");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.price          <= '0;
        in_ch.last_of_series <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_WINDOW_A;
        cfg_wdata            <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_windows();
        test_short_windows();
        test_window_change();

        write_all_windows(win_t'($urandom_range(0, 127)), win_t'($urandom_range(0, 127)),
                          win_t'($urandom_range(0, 127)), win_t'($urandom_range(0, 127)));
        test_random_series(200, 20);
        write_all_windows(7'd64, 7'd64, 7'd64, 7'd64);
        test_random_series(200, 30);
        write_all_windows(7'd127, 7'd127, 7'd127, 7'd127);
        test_random_series(150, 0);
        write_all_windows(7'd0, 7'd1, 7'd2, 7'd3);
        test_random_series(150, 40);
        write_all_windows(win_t'($urandom_range(2, 12)), win_t'($urandom_range(2, 12)),
                          win_t'($urandom_range(2, 12)), win_t'($urandom_range(2, 12)));
        test_random_series(250, 20);
        // Closing stretch at full rate with the reset lengths.
        write_all_windows(7'd5, 7'd10, 7'd30, 7'd60);
        test_random_series(180, 0);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d prices in %0d closed series, checked %0d average sets,",
                 prices_sent, series_sent, results_seen);
        $display("over %0d window register writes including lengths 0, 1, 64 and 127.",
                 window_writes);
        if (mismatch_count == 0 && expected_avgs.size() == 0)
            $display("multi_window_moving_average_core_tb: clean");
        else
            $display("multi_window_moving_average_core_tb: errors");
        $finish;
    end

endmodule
